FILE: rtl/tsps_pkg.sv
`default_nettype none

package tsps_pkg;

    localparam int MAX_STEPS = 16;
    localparam int STEP_W    = 4;
    localparam int COUNT_W   = 5;

    // epoch seconds of 2000-01-01; anything at or below is an unset clock
    localparam logic [31:0] CLOCK_VALID_AFTER = 32'd946684800;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_RESUME = 3'd3,
        OP_STOP   = 3'd4,
        OP_NEXT   = 3'd5,
        OP_PREV   = 3'd6,
        OP_WRITE  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RUNNING  = 3'd1,
        ST_AWAITING = 3'd2,
        ST_PAUSED   = 3'd3,
        ST_DONE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_STATE      = 2'd1,
        ERR_NO_STEPS   = 2'd2,
        ERR_UNKNOWN_OP = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        APPLY_NONE    = 2'd0,
        APPLY_STEP    = 2'd1,
        APPLY_REBUILD = 2'd2
    } apply_t;

    typedef struct packed {
        logic [31:0] hold_sec;
        logic        by_sensor;
        logic        confirm;
    } step_entry_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] now_sec;
        logic        sensor_fired;
        logic        targets_ok;
        logic [3:0]  entry_index;
        logic [31:0] entry_hold_sec;
        logic        entry_by_sensor;
        logic        entry_confirm;
        logic        entry_last;
    } req_t;

    typedef struct packed {
        logic        accepted;
        err_t        error_code;
        status_t     run_status;
        logic [3:0]  step_now;
        apply_t      apply_command;
        logic        with_impulse;
        logic        status_changed;
        logic [31:0] remaining_sec;
        logic        save_request;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/timed_step_program_sequencer.sv
`default_nettype none

// Step program sequencer: idle, running, awaiting, paused and done.
// Request channel (req_valid / req_stall / req) carries one operation per
// transfer: tick, start, pause, resume, stop, next, prev or a step-table write.
// Response channel (rsp_valid / rsp_stall / rsp) returns exactly one result
// per request, in order: acceptance, error code, status, step, apply command
// with impulse flag, remaining seconds of the current step and save request.
// A taken request waits in the request register and its result is written
// to the response register. Throughput: one request per cycle while rsp is
// not stalled; the whole decision is one pass of logic between the two registers.
// The request register keeps taking transfers while a result waits on a
// stalled rsp, as long as that register is free; req_stall rises only when
// both registers hold work and rsp_stall is high.
// Reset (rst_n low, asynchronous) empties both registers and sets the run to
// idle at step 0 with no program loaded. Step-table contents are not reset;
// write the entries and finish with the last-entry flag before starting.

module timed_step_program_sequencer
    import tsps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic req_valid,
    output      logic req_stall,
    input  wire req_t req,

    output      logic rsp_valid,
    input  wire logic rsp_stall,
    output      rsp_t rsp
);

    req_t        req_reg;
    logic        req_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        rsp_valid_reg;

    status_t     status_reg, status_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  reached_reg, reached_next;
    logic        none_reached_reg, none_reached_next;
    logic [31:0] started_reg, started_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    step_entry_t cur_entry_reg, cur_entry_next;
    step_entry_t table_reg [MAX_STEPS];

    logic        rsp_adv;
    logic        fire;
    logic        clock_valid;
    logic        live;
    logic        idx_ok;
    logic        do_write;
    step_entry_t new_entry;
    logic [STEP_W-1:0]  adv_idx;
    logic        adv_done;
    logic        adv_first;
    logic        due;
    logic        in_step;
    logic        accepted;
    err_t        err;
    apply_t      apply_cmd;
    logic        impulse;
    logic        save;
    logic [34:0] run_span;
    logic [34:0] run_rem;
    logic [34:0] pause_rem;
    logic [34:0] rem_raw;
    logic [31:0] remaining;

    assign rsp_adv   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && rsp_adv;
    assign req_stall = req_valid_reg && !rsp_adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign clock_valid = req_reg.now_sec > CLOCK_VALID_AFTER;
    assign live        = (status_reg == ST_RUNNING) || (status_reg == ST_PAUSED) ||
                         (status_reg == ST_AWAITING);
    assign idx_ok      = {1'b0, req_reg.entry_index} < COUNT_W'(MAX_STEPS);
    assign do_write    = fire && (req_reg.operation == OP_WRITE) && idx_ok;
    assign new_entry   = '{hold_sec:  req_reg.entry_hold_sec,
                           by_sensor: req_reg.entry_by_sensor,
                           confirm:   req_reg.entry_confirm};

    assign adv_idx   = step_reg + STEP_W'(1);
    assign adv_done  = ({1'b0, step_reg} + COUNT_W'(1)) >= count_reg;
    assign adv_first = none_reached_reg || (adv_idx > reached_reg);
    assign in_step   = {1'b0, step_reg} < count_reg;

    always_comb
    begin
        if (cur_entry_reg.by_sensor)
        begin
            due = req_reg.sensor_fired;
        end
        else
        begin
            due = (req_reg.now_sec >= started_reg) &&
                  ((req_reg.now_sec - started_reg) >= cur_entry_reg.hold_sec);
        end
    end

    // decision for the item in the request register
    always_comb
    begin
        status_next       = status_reg;
        step_next         = step_reg;
        reached_next      = reached_reg;
        none_reached_next = none_reached_reg;
        started_next      = started_reg;
        elapsed_next      = elapsed_reg;
        count_next        = count_reg;
        accepted          = 1'b1;
        err               = ERR_NONE;
        apply_cmd         = APPLY_NONE;
        impulse           = 1'b0;
        save              = 1'b0;

        case (req_reg.operation)
            OP_TICK:
            begin
                if (clock_valid && (status_reg == ST_RUNNING) && in_step &&
                    due && req_reg.targets_ok)
                begin
                    save = 1'b1;
                    if (cur_entry_reg.confirm)
                    begin
                        status_next = ST_AWAITING;
                    end
                    else if (adv_done)
                    begin
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        status_next  = ST_RUNNING;
                        step_next    = adv_idx;
                        started_next = req_reg.now_sec;
                        elapsed_next = '0;
                        apply_cmd    = APPLY_STEP;
                        impulse      = adv_first;
                        if (adv_first)
                        begin
                            reached_next      = adv_idx;
                            none_reached_next = 1'b0;
                        end
                    end
                end
            end
            OP_START:
            begin
                if ((status_reg != ST_IDLE) && (status_reg != ST_DONE))
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else if (count_reg == '0)
                begin
                    accepted = 1'b0;
                    err      = ERR_NO_STEPS;
                end
                else
                begin
                    status_next       = ST_RUNNING;
                    step_next         = '0;
                    started_next      = req_reg.now_sec;
                    elapsed_next      = '0;
                    reached_next      = '0;
                    none_reached_next = 1'b0;
                    apply_cmd         = APPLY_STEP;
                    impulse           = 1'b1;
                end
            end
            OP_PAUSE:
            begin
                if (status_reg == ST_RUNNING)
                begin
                    // clamp at zero if the clock went back
                    elapsed_next = (req_reg.now_sec >= started_reg) ?
                                   (req_reg.now_sec - started_reg) : '0;
                    status_next  = ST_PAUSED;
                end
                else if (status_reg == ST_AWAITING)
                begin
                    elapsed_next = cur_entry_reg.hold_sec;
                    status_next  = ST_PAUSED;
                end
                else
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
            end
            OP_RESUME:
            begin
                if (status_reg != ST_PAUSED)
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else
                begin
                    started_next = (req_reg.now_sec >= elapsed_reg) ?
                                   (req_reg.now_sec - elapsed_reg) : '0;
                    status_next  = ST_RUNNING;
                    apply_cmd    = APPLY_STEP;
                end
            end
            OP_STOP:
            begin
                if (status_reg == ST_IDLE)
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else
                begin
                    status_next  = ST_IDLE;
                    step_next    = '0;
                    elapsed_next = '0;
                end
            end
            OP_NEXT:
            begin
                if (!live)
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else if (adv_done)
                begin
                    status_next = ST_DONE;
                end
                else
                begin
                    status_next  = ST_RUNNING;
                    step_next    = adv_idx;
                    started_next = req_reg.now_sec;
                    elapsed_next = '0;
                    apply_cmd    = APPLY_STEP;
                    impulse      = adv_first;
                    if (adv_first)
                    begin
                        reached_next      = adv_idx;
                        none_reached_next = 1'b0;
                    end
                end
            end
            OP_PREV:
            begin
                if (!live)
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else
                begin
                    if (step_reg != '0)
                    begin
                        step_next = step_reg - STEP_W'(1);
                    end
                    status_next  = ST_RUNNING;
                    started_next = req_reg.now_sec;
                    elapsed_next = '0;
                    apply_cmd    = APPLY_REBUILD;
                end
            end
            OP_WRITE:
            begin
                if (!idx_ok)
                begin
                    accepted = 1'b0;
                    err      = ERR_STATE;
                end
                else if (req_reg.entry_last)
                begin
                    count_next        = {1'b0, req_reg.entry_index} + COUNT_W'(1);
                    status_next       = ST_IDLE;
                    step_next         = '0;
                    none_reached_next = 1'b1;
                    started_next      = '0;
                    elapsed_next      = '0;
                end
            end
            default:
            begin
                accepted = 1'b0;
                err      = ERR_UNKNOWN_OP;
            end
        endcase
    end

    // current step entry after this item; bypass a write to the same slot
    always_comb
    begin
        if (do_write && (req_reg.entry_index == step_next))
        begin
            cur_entry_next = new_entry;
        end
        else
        begin
            cur_entry_next = table_reg[step_next];
        end
    end

    assign run_span  = {3'b000, req_reg.now_sec} - {3'b000, started_next};
    assign run_rem   = {3'b000, cur_entry_next.hold_sec} - run_span;
    assign pause_rem = {3'b000, cur_entry_next.hold_sec} - {3'b000, elapsed_next};

    always_comb
    begin
        if ({1'b0, step_next} >= count_next)
        begin
            rem_raw = '0;
        end
        else if (cur_entry_next.by_sensor)
        begin
            rem_raw = '0;
        end
        else if ((status_next == ST_RUNNING) && clock_valid)
        begin
            rem_raw = run_rem;
        end
        else if (status_next == ST_PAUSED)
        begin
            rem_raw = pause_rem;
        end
        else if ((status_next == ST_AWAITING) || (status_next == ST_DONE))
        begin
            rem_raw = '0;
        end
        else
        begin
            rem_raw = {3'b000, cur_entry_next.hold_sec};
        end
    end

    // clamp to 0 .. 2^32-1; bit 34 is the sign
    always_comb
    begin
        if (rem_raw[34])
        begin
            remaining = '0;
        end
        else if (rem_raw[33:32] != 2'b00)
        begin
            remaining = '1;
        end
        else
        begin
            remaining = rem_raw[31:0];
        end
    end

    always_comb
    begin
        rsp_next.accepted       = accepted;
        rsp_next.error_code     = err;
        rsp_next.run_status     = status_next;
        rsp_next.step_now       = step_next;
        rsp_next.apply_command  = apply_cmd;
        rsp_next.with_impulse   = impulse;
        rsp_next.status_changed = status_next != status_reg;
        rsp_next.remaining_sec  = remaining;
        rsp_next.save_request   = save;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            status_reg       <= ST_IDLE;
            step_reg         <= '0;
            reached_reg      <= '0;
            none_reached_reg <= 1'b1;
            started_reg      <= '0;
            elapsed_reg      <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (rsp_adv)
            begin
                rsp_valid_reg <= fire;
            end
            if (fire)
            begin
                status_reg       <= status_next;
                step_reg         <= step_next;
                reached_reg      <= reached_next;
                none_reached_reg <= none_reached_next;
                started_reg      <= started_next;
                elapsed_reg      <= elapsed_next;
                count_reg        <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg       <= rsp_next;
            cur_entry_reg <= cur_entry_next;
        end
        if (do_write)
        begin
            table_reg[req_reg.entry_index] <= new_entry;
        end
    end

endmodule

`default_nettype wire

FILE: sim/timed_step_program_sequencer_tb.sv
`default_nettype none

module timed_step_program_sequencer_tb;
    import tsps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int RANDOM_ITEMS   = 500;
    localparam logic [31:0] FIRST_VALID = CLOCK_VALID_AFTER + 32'd1;

    typedef struct {
        req_t op;
        bit   drain;
    } send_slot_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    timed_step_program_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Sequencer state as this bench tracks it
    status_t     cur_status     = ST_IDLE;
    logic [3:0]  cur_step       = '0;
    int          top_reached    = -1;
    logic [31:0] step_start     = '0;
    logic [31:0] paused_elapsed = '0;
    int          prog_len       = 0;
    logic [31:0] hold_tab    [MAX_STEPS];
    bit          sensor_tab  [MAX_STEPS];
    bit          confirm_tab [MAX_STEPS];
    apply_t      apply_out;
    bit          impulse_out;

    send_slot_t  ops_to_send [$];
    rsp_t        results_owed [$];
    bit          drain_next   = 1'b0;
    bit [15:0]   entries_set  = '0;
    logic [31:0] wall         = FIRST_VALID + 32'd1000;
    int          items_made   = 0;

    int errors       = 0;
    int idle_cycles  = 0;
    int results_seen = 0;
    bit req_taken    = 1'b0;

    bit offering   = 1'b0;
    int send_gap   = 0;
    int items_sent = 0;

    int stall_left    = 0;
    int free_left     = 0;
    int rx_cycles     = 0;
    bit holdoff_armed = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void enter_step(int idx, logic [31:0] now);
        impulse_out = idx > top_reached;
        if (idx > top_reached)
            top_reached = idx;
        cur_step       = idx[3:0];
        step_start     = now;
        paused_elapsed = '0;
        cur_status     = ST_RUNNING;
        apply_out      = APPLY_STEP;
    endfunction

    function automatic void advance_step(logic [31:0] now);
        if (cur_step + 1 >= prog_len)
            cur_status = ST_DONE;
        else
            enter_step(cur_step + 1, now);
    endfunction

    function automatic rsp_t run_op(req_t r);
        rsp_t    o;
        status_t was;
        err_t    err;
        bit      live, due, save;
        longint  now_l, start_l, hold_l, left;
        was         = cur_status;
        live        = cur_status == ST_RUNNING || cur_status == ST_PAUSED ||
                      cur_status == ST_AWAITING;
        now_l       = r.now_sec;
        err         = ERR_NONE;
        save        = 1'b0;
        apply_out   = APPLY_NONE;
        impulse_out = 1'b0;

        case (r.operation)
            OP_TICK:
            begin
                if (r.now_sec > CLOCK_VALID_AFTER && cur_status == ST_RUNNING &&
                    cur_step < prog_len)
                begin
                    start_l = step_start;
                    hold_l  = hold_tab[cur_step];
                    if (sensor_tab[cur_step])
                        due = r.sensor_fired;
                    else
                        due = now_l - start_l >= hold_l;
                    // a due step holds while its targets cannot be resolved
                    if (due && r.targets_ok)
                    begin
                        if (confirm_tab[cur_step])
                            cur_status = ST_AWAITING;
                        else
                            advance_step(r.now_sec);
                        save = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                if (cur_status != ST_IDLE && cur_status != ST_DONE)
                    err = ERR_STATE;
                else if (prog_len == 0)
                    err = ERR_NO_STEPS;
                else
                begin
                    top_reached = -1;
                    enter_step(0, r.now_sec);
                end
            end
            OP_PAUSE:
            begin
                if (cur_status == ST_RUNNING)
                begin
                    // clock went back: clamp elapsed at zero
                    paused_elapsed = r.now_sec >= step_start ? r.now_sec - step_start : '0;
                    cur_status     = ST_PAUSED;
                end
                else if (cur_status == ST_AWAITING)
                begin
                    paused_elapsed = hold_tab[cur_step];
                    cur_status     = ST_PAUSED;
                end
                else
                    err = ERR_STATE;
            end
            OP_RESUME:
            begin
                if (cur_status != ST_PAUSED)
                    err = ERR_STATE;
                else
                begin
                    step_start = r.now_sec >= paused_elapsed ?
                                 r.now_sec - paused_elapsed : '0;
                    cur_status = ST_RUNNING;
                    apply_out  = APPLY_STEP;
                end
            end
            OP_STOP:
            begin
                if (cur_status == ST_IDLE)
                    err = ERR_STATE;
                else
                begin
                    cur_status     = ST_IDLE;
                    cur_step       = '0;
                    paused_elapsed = '0;
                end
            end
            OP_NEXT:
            begin
                if (!live)
                    err = ERR_STATE;
                else
                    advance_step(r.now_sec);
            end
            OP_PREV:
            begin
                if (!live)
                    err = ERR_STATE;
                else
                begin
                    if (cur_step > 0)
                        cur_step = cur_step - 4'd1;
                    cur_status     = ST_RUNNING;
                    step_start     = r.now_sec;
                    paused_elapsed = '0;
                    apply_out      = APPLY_REBUILD;
                end
            end
            default:
            begin
                hold_tab[r.entry_index]    = r.entry_hold_sec;
                sensor_tab[r.entry_index]  = r.entry_by_sensor;
                confirm_tab[r.entry_index] = r.entry_confirm;
                if (r.entry_last)
                begin
                    prog_len       = r.entry_index + 1;
                    cur_status     = ST_IDLE;
                    cur_step       = '0;
                    top_reached    = -1;
                    step_start     = '0;
                    paused_elapsed = '0;
                end
            end
        endcase

        left = 0;
        if (cur_step < prog_len && !sensor_tab[cur_step])
        begin
            hold_l  = hold_tab[cur_step];
            start_l = step_start;
            case (cur_status)
                ST_RUNNING:
                    left = r.now_sec > CLOCK_VALID_AFTER ? hold_l - (now_l - start_l) : hold_l;
                ST_PAUSED:
                    left = hold_l - longint'(paused_elapsed);
                ST_AWAITING, ST_DONE:
                    left = 0;
                default:
                    left = hold_l;
            endcase
            if (left < 0)
                left = 0;
            if (left > longint'(32'hFFFF_FFFF))
                left = longint'(32'hFFFF_FFFF);
        end

        o.accepted       = err == ERR_NONE;
        o.error_code     = err;
        o.run_status     = cur_status;
        o.step_now       = cur_step;
        o.apply_command  = apply_out;
        o.with_impulse   = impulse_out;
        o.status_changed = cur_status != was;
        o.remaining_sec  = left[31:0];
        o.save_request   = save;
        return o;
    endfunction

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // mostly a wall clock creeping forward; sometimes back, unset or wild
    function automatic logic [31:0] pick_now();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            wall = wall + $urandom_range(0, 3);
        else if (r < 80)
            wall = wall + $urandom_range(4, 20);
        else if (r < 86)
            wall = wall + $urandom_range(21, 2000);
        else if (r < 92)
            wall = wall - $urandom_range(1, 6);
        else if (r < 96)
            return r[0] ? CLOCK_VALID_AFTER : $urandom_range(0, CLOCK_VALID_AFTER);
        else
            return $urandom;
        return wall;
    endfunction

    function automatic logic [31:0] pick_hold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 4);
        if (r < 70)
            return $urandom_range(5, 40);
        if (r < 80)
            return '0;
        if (r < 90)
            return $urandom_range(1000, 100000);
        return $urandom;
    endfunction

    function automatic int set_prefix();
        int n;
        n = 0;
        while (n < MAX_STEPS && entries_set[n])
            n++;
        return n;
    endfunction

    function automatic req_t make_op(op_t op);
        req_t r;
        r.operation       = op;
        r.now_sec         = pick_now();
        r.sensor_fired    = $urandom_range(0, 2) == 0;
        r.targets_ok      = $urandom_range(0, 6) != 0;
        r.entry_index     = 4'($urandom);
        r.entry_hold_sec  = $urandom;
        r.entry_by_sensor = 1'($urandom);
        r.entry_confirm   = 1'($urandom);
        r.entry_last      = 1'($urandom);
        return r;
    endfunction

    task automatic queue_op(req_t r);
        send_slot_t slot;
        slot.op    = r;
        slot.drain = drain_next;
        ops_to_send.insert(ops_to_send.size(), slot);
        drain_next = 1'b0;
        items_made++;
    endtask

    task automatic queue_at(op_t op, logic [31:0] now, bit sensor, bit tok);
        req_t r;
        r              = make_op(op);
        r.now_sec      = now;
        r.sensor_fired = sensor;
        r.targets_ok   = tok;
        queue_op(r);
    endtask

    // the last flag is only ever set once every lower entry holds data
    task automatic queue_write(int idx, logic [31:0] hold, bit by_sensor, bit confirm,
                               bit last);
        req_t r;
        r                 = make_op(OP_WRITE);
        r.entry_index     = idx[3:0];
        r.entry_hold_sec  = hold;
        r.entry_by_sensor = by_sensor;
        r.entry_confirm   = confirm;
        r.entry_last      = last;
        entries_set[idx]  = 1'b1;
        queue_op(r);
    endtask

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        rsp_t want;
        bit   rsp_taken;
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            rsp_taken = rsp_valid && !rsp_stall;
            if (rsp_taken)
            begin
                results_seen++;
                if (results_owed.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, got %h", $time, rsp);
                end
                else
                begin
                    want = results_owed.pop_front();
                    check_field("accepted", want.accepted, rsp.accepted);
                    check_field("error_code", want.error_code, rsp.error_code);
                    check_field("run_status", want.run_status, rsp.run_status);
                    check_field("step_now", want.step_now, rsp.step_now);
                    check_field("apply_command", want.apply_command, rsp.apply_command);
                    check_field("with_impulse", want.with_impulse, rsp.with_impulse);
                    check_field("status_changed", want.status_changed, rsp.status_changed);
                    check_field("remaining_sec", want.remaining_sec, rsp.remaining_sec);
                    check_field("save_request", want.save_request, rsp.save_request);
                end
            end
            if (req_taken)
                results_owed.insert(results_owed.size(), run_op(req));
            if (req_taken || rsp_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // request side: hold the payload until the transfer, then idle a while
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                void'(ops_to_send.pop_front());
                items_sent++;
                offering  = 1'b0;
                send_gap  = ((items_sent / 50) % 4 == 3) ? 0 : idle_len();
            end
            if (!offering && ops_to_send.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!ops_to_send[0].drain || results_owed.size() == 0)
                begin
                    offering = 1'b1;
                    req <= ops_to_send[0].op;
                end
            end
            req_valid <= offering;
        end
    end

    // response side: random stalls, quiet stretches and one long hold-off
    always @(negedge clk)
    begin
        bit s;
        if (rst_n)
        begin
            rx_cycles++;
            if (holdoff_armed && results_seen >= 150 && req_valid)
            begin
                holdoff_armed = 1'b0;
                stall_left    = 60;
                free_left     = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                if ((rx_cycles / 400) % 3 == 1)
                    free_left = 40;
                else
                begin
                    free_left  = $urandom_range(1, 6);
                    stall_left = idle_len();
                end
            end
            if (stall_left > 0)
            begin
                s = 1'b1;
                stall_left--;
            end
            else
            begin
                s = 1'b0;
                free_left--;
            end
            rsp_stall <= s;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int r, n, idx;
        req_t item;

        // no program loaded yet
        queue_at(OP_TICK, 32'd0, 1'b0, 1'b1);
        queue_at(OP_START, FIRST_VALID, 1'b0, 1'b1);
        queue_at(OP_STOP, FIRST_VALID, 1'b0, 1'b1);
        queue_at(OP_PAUSE, FIRST_VALID, 1'b0, 1'b1);
        queue_at(OP_NEXT, FIRST_VALID, 1'b0, 1'b1);
        // timed step, sensor step, confirm step
        queue_write(0, 32'd3, 1'b0, 1'b0, 1'b0);
        queue_write(1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        queue_write(2, 32'd2, 1'b0, 1'b1, 1'b1);
        queue_at(OP_START, FIRST_VALID, 1'b0, 1'b1);
        queue_at(OP_TICK, CLOCK_VALID_AFTER, 1'b1, 1'b1);
        queue_at(OP_TICK, FIRST_VALID + 32'd2, 1'b0, 1'b1);
        queue_at(OP_TICK, FIRST_VALID + 32'd3, 1'b0, 1'b0);
        queue_at(OP_TICK, FIRST_VALID + 32'd3, 1'b0, 1'b1);
        queue_at(OP_TICK, FIRST_VALID + 32'd5, 1'b0, 1'b1);
        queue_at(OP_TICK, FIRST_VALID + 32'd6, 1'b1, 1'b1);
        queue_at(OP_PAUSE, FIRST_VALID + 32'd7, 1'b0, 1'b1);
        queue_at(OP_RESUME, FIRST_VALID + 32'd10, 1'b0, 1'b1);
        queue_at(OP_TICK, FIRST_VALID + 32'd11, 1'b0, 1'b1);
        queue_at(OP_PAUSE, FIRST_VALID + 32'd12, 1'b0, 1'b1);
        // resume with a clock below the elapsed time saturates the start
        queue_at(OP_RESUME, 32'd1, 1'b0, 1'b1);
        queue_at(OP_NEXT, FIRST_VALID + 32'd13, 1'b0, 1'b1);
        queue_at(OP_NEXT, FIRST_VALID + 32'd13, 1'b0, 1'b1);
        queue_at(OP_START, FIRST_VALID + 32'd14, 1'b0, 1'b1);
        queue_at(OP_PREV, FIRST_VALID + 32'd15, 1'b0, 1'b1);
        queue_write(3, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_at(OP_STOP, FIRST_VALID + 32'd16, 1'b0, 1'b1);
        queue_at(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);

        while (items_made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                drain_next = 1'b1;
            if ($urandom_range(0, 9) < 7)
            begin
                r = $urandom_range(0, 99);
                n = r < 70 ? $urandom_range(1, 4) :
                    r < 92 ? $urandom_range(5, 8) : $urandom_range(9, MAX_STEPS);
                for (int i = 0; i < n; i++)
                    queue_write(i, pick_hold(), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 3) == 0, i == n - 1);
            end
            if ($urandom_range(0, 3) != 0)
                queue_op(make_op(OP_START));
            repeat ($urandom_range(5, 25))
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    queue_op(make_op(OP_TICK));
                else if (r < 53)
                    queue_op(make_op(OP_NEXT));
                else if (r < 60)
                    queue_op(make_op(OP_PREV));
                else if (r < 68)
                    queue_op(make_op(OP_PAUSE));
                else if (r < 76)
                    queue_op(make_op(OP_RESUME));
                else if (r < 80)
                    queue_op(make_op(OP_STOP));
                else if (r < 84)
                    queue_op(make_op(OP_START));
                else if (r < 90)
                begin
                    idx = $urandom_range(0, MAX_STEPS - 1);
                    queue_write(idx, pick_hold(), 1'($urandom), 1'($urandom),
                                idx < set_prefix() && $urandom_range(0, 3) == 0);
                end
                else
                begin
                    item         = make_op(op_t'(3'($urandom_range(0, 6))));
                    item.now_sec = $urandom;
                    queue_op(item);
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || results_owed.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/tsps_pkg.sv
rtl/timed_step_program_sequencer.sv
sim/timed_step_program_sequencer_tb.sv
